// File: sv/cpsf_pkg.sv
package cpsf_pkg;
  localparam int unsigned DimensionsDefault = 2;
  localparam int unsigned CellCountDefault  = 1024;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ProtW  = 16;
  localparam int unsigned KW     = 20;
  localparam int unsigned ForceW = 32;
  localparam int unsigned InW    = 184;
  localparam int unsigned OutW   = 64;
  localparam int unsigned SqrtSteps = 16;
  localparam int unsigned DivSteps  = 40;

  localparam logic [KW-1:0]   SpringConstReset = 20'd256000;
  localparam logic [PosW-1:0] RestLengthReset  = 16'd328;
  localparam logic [PosW-1:0] InterDistReset   = 16'd1311;

  typedef enum logic [1:0] {
    RegSpringConst = 2'd0,
    RegRestLength  = 2'd1,
    RegInterDist   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [KW-1:0]   spring_const;
    logic [PosW-1:0] rest_length;
    logic [PosW-1:0] interaction_dist;
  } cfg_t;
endpackage

// File: sv/cpsf_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module cpsf_sqrt import cpsf_pkg::*; #(
  parameter int unsigned SideW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [33:0]          rad_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [16:0]          root_o,
  output logic [SideW-1:0]     side_o
);
  localparam int unsigned N = 17;
  logic [N:0]       vld_q;
  logic [33:0]      rem_q  [N+1];
  logic [16:0]      res_q  [N+1];
  logic [SideW-1:0] side_q [N+1];

  always_comb begin
    rem_q[0]  = rad_i;
    res_q[0]  = '0;
    side_q[0] = side_i;
  end
  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [33:0] trial;
    logic        ok;
    logic [16:0] bit_s;
    logic [33:0] rem_d;
    logic [16:0] res_d;
    logic [33:0] rem_r;
    logic [16:0] res_r;
    logic [SideW-1:0] side_r;
    logic        vld_r;
    always_comb begin
      bit_s = 17'd1 << (N-1-s);
      trial = ({17'd0, res_q[s]} << (N-s)) + ({17'd0, bit_s} << (N-1-s));
      ok    = rem_q[s] >= trial;
      rem_d = ok ? rem_q[s] - trial : rem_q[s];
      res_d = ok ? (res_q[s] | bit_s) : res_q[s];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else if (en_i) begin
        vld_r <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r  <= rem_d;
        res_r  <= res_d;
        side_r <= side_q[s];
      end
    end
    assign vld_q[s+1] = vld_r;
    always_comb begin
      rem_q[s+1]  = rem_r;
      res_q[s+1]  = res_r;
      side_q[s+1] = side_r;
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = res_q[N];
  assign side_o  = side_q[N];
endmodule

// File: sv/cpsf_div.sv
// Pipelined restoring divider, one quotient bit per stage; q = num / den.
module cpsf_div import cpsf_pkg::*; #(
  parameter int unsigned NumW  = 40,
  parameter int unsigned DenW  = 17,
  parameter int unsigned SideW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);
  localparam int unsigned RW = DenW + 1;
  logic [NumW:0]    vld;
  logic [RW-1:0]    rem  [NumW+1];
  logic [NumW-1:0]  num  [NumW+1];
  logic [DenW-1:0]  den  [NumW+1];
  logic [SideW-1:0] side [NumW+1];

  assign vld[0] = valid_i;
  always_comb begin
    rem[0]  = '0;
    num[0]  = num_i;
    den[0]  = den_i;
    side[0] = side_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_st
    logic [RW-1:0]   sh;
    logic            ok;
    logic [RW-1:0]   rem_r;
    logic [NumW-1:0] num_r;
    logic [DenW-1:0] den_r;
    logic [SideW-1:0] side_r;
    logic            vld_r;
    always_comb begin
      sh = {rem[s][RW-2:0], num[s][NumW-1]};
      ok = sh >= {1'b0, den[s]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else if (en_i) begin
        vld_r <= vld[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r  <= ok ? sh - {1'b0, den[s]} : sh;
        num_r  <= {num[s][NumW-2:0], ok};
        den_r  <= den[s];
        side_r <= side[s];
      end
    end
    assign vld[s+1] = vld_r;
    always_comb begin
      rem[s+1]  = rem_r;
      num[s+1]  = num_r;
      den[s+1]  = den_r;
      side[s+1] = side_r;
    end
  end

  assign valid_o = vld[NumW];
  assign quo_o   = num[NumW];
  assign side_o  = side[NumW];
endmodule

// File: sv/cell_pair_spring_force.sv
// cell_pair_spring_force: spring force on node A of one candidate node pair.
// Channels:
//   cfg_*  : register writes (index 0 spring_const, 1 rest_length,
//            2 interaction_dist); always ready. Write only while idle.
//   s_axis : one pair per transaction, fields packed in tdata.
//   m_axis : one result per pair: force_x, force_y, interacting, clipped.
// Throughput: one pair per cycle unless the receiver stalls. There are 65
// register stages: 3 + 17 (square-root stages) + 2 + 40 (divider stages,
// x and y in parallel) + 3; the chain of iteration stages dominates.
// The whole pipeline advances together: when the receiver stalls with a
// result held, every stage holds and s_axis_tready drops; an empty output
// slot lets the pipe move. Reset empties the pipe (valid bits only) and
// loads the register defaults.
module cell_pair_spring_force import cpsf_pkg::*; #(
  parameter int unsigned DIMENSIONS = DimensionsDefault,
  parameter int unsigned CELL_COUNT = CellCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_a_x, pos_a_y, pos_b_x, pos_b_y, cell_of_a, cell_of_b, ecad_a, pcad_a,
  // integrin_a, ecad_b, pcad_b, integrin_b
  input  logic [InW-1:0]    s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // force_x, force_y
  output logic [OutW-1:0]   m_axis_tdata,
  // interacting, clipped
  output logic [1:0]        m_axis_tuser
);
  // Datapath covers two coordinates; cell ids are plain bit patterns.
  localparam int unsigned DimUsed = (DIMENSIONS >= 2) ? 2 : DIMENSIONS;
  localparam int unsigned CellIdW = (CELL_COUNT > 1024) ? 10 : $clog2(CELL_COUNT);

  cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spring_const     <= SpringConstReset;
      cfg_q.rest_length      <= RestLengthReset;
      cfg_q.interaction_dist <= InterDistReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSpringConst: cfg_q.spring_const     <= cfg_data_i[KW-1:0];
        RegRestLength:  cfg_q.rest_length      <= cfg_data_i[PosW-1:0];
        RegInterDist:   cfg_q.interaction_dist <= cfg_data_i[PosW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---- stage 1: differences, protein min/max
  logic [15:0] ax, ay, bx, by;
  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign bx = s_axis_tdata[47:32];
  assign by = s_axis_tdata[63:48];
  logic [9:0] ca, cb;
  assign ca = s_axis_tdata[73:64];
  assign cb = s_axis_tdata[83:74];
  logic [15:0] ea, pa, ia, eb, pb, ib;
  assign ea = s_axis_tdata[99:84];
  assign pa = s_axis_tdata[115:100];
  assign ia = s_axis_tdata[131:116];
  assign eb = s_axis_tdata[147:132];
  assign pb = s_axis_tdata[163:148];
  assign ib = s_axis_tdata[179:164];

  logic        v1_q, v2_q, v3_q;
  logic [15:0] mx1_q, my1_q;
  logic        nx1_q, ny1_q, diff1_q;
  logic [15:0] e1_q, p1_q, i1_q;
  logic        same_id;
  assign same_id = (CellIdW == 0) ? 1'b0 :
                   (ca[CellIdW-1:0] == cb[CellIdW-1:0]) && (ca == cb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid; v2_q <= v1_q; v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx1_q   <= bx < ax;
      ny1_q   <= (DimUsed > 1) && (by < ay);
      mx1_q   <= (bx < ax) ? ax - bx : bx - ax;
      my1_q   <= (DimUsed < 2) ? 16'd0 : ((by < ay) ? ay - by : by - ay);
      diff1_q <= !same_id;
      e1_q    <= (ea < eb) ? ea : eb;
      p1_q    <= (pa < pb) ? pa : pb;
      i1_q    <= (ia > ib) ? ia : ib;
    end
  end

  // ---- stage 2: squares, multiplier sum
  logic [31:0] sqx2_q, sqy2_q, lim2_q;
  logic [15:0] mx2_q, my2_q;
  logic        nx2_q, ny2_q, diff2_q;
  logic [17:0] m2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx2_q  <= mx1_q * mx1_q;
      sqy2_q  <= my1_q * my1_q;
      lim2_q  <= cfg_q.interaction_dist * cfg_q.interaction_dist;
      mx2_q <= mx1_q; my2_q <= my1_q; nx2_q <= nx1_q; ny2_q <= ny1_q;
      diff2_q <= diff1_q;
      m2_q <= {2'b0, e1_q} + {2'b0, p1_q} + {2'b0, i1_q};
    end
  end

  // ---- stage 3: squared distance, interaction test, k*m
  logic [32:0] d2_3_q;
  logic        int3_q;
  logic [15:0] mx3_q, my3_q;
  logic        nx3_q, ny3_q;
  logic [37:0] km3_q;
  logic [32:0] d2_s;
  assign d2_s = {1'b0, sqx2_q} + {1'b0, sqy2_q};
  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_3_q <= d2_s;
      int3_q <= diff2_q && (d2_s != 33'd0) && (d2_s < {1'b0, lim2_q});
      mx3_q <= mx2_q; my3_q <= my2_q; nx3_q <= nx2_q; ny3_q <= ny2_q;
      km3_q <= cfg_q.spring_const * m2_q;
    end
  end

  // ---- square root
  localparam int unsigned SqSideW = 1 + 16 + 16 + 2 + 38;
  logic              vs_o;
  logic [16:0]       root;
  logic [SqSideW-1:0] sq_side;
  cpsf_sqrt #(.SideW(SqSideW)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q),
    .rad_i({1'b0, d2_3_q}),
    .side_i({int3_q, mx3_q, my3_q, nx3_q, ny3_q, km3_q}),
    .valid_o(vs_o), .root_o(root), .side_o(sq_side)
  );
  logic        int_s, nx_s, ny_s;
  logic [15:0] mx_s, my_s;
  logic [37:0] km_s;
  assign {int_s, mx_s, my_s, nx_s, ny_s, km_s} = sq_side;

  // ---- stage 4: |d - rest|
  logic        v4_q, int4_q, sx4_q, sy4_q;
  logic [16:0] d4_q, dl4_q;
  logic [15:0] mx4_q, my4_q;
  logic [37:0] km4_q;
  logic        dneg;
  assign dneg = root < {1'b0, cfg_q.rest_length};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= vs_o;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      int4_q <= int_s;
      d4_q   <= (root == 17'd0) ? 17'd1 : root;
      dl4_q  <= dneg ? {1'b0, cfg_q.rest_length} - root : root - {1'b0, cfg_q.rest_length};
      sx4_q  <= dneg != nx_s;
      sy4_q  <= dneg != ny_s;
      mx4_q <= mx_s; my4_q <= my_s; km4_q <= km_s;
    end
  end

  // ---- stage 5: dl * |dc| << 8
  // An interacting pair has d below 2^16, so dl fits 16 bits there.
  logic        v5_q, int5_q, sx5_q, sy5_q;
  logic [16:0] d5_q;
  logic [39:0] nx5_q, ny5_q;
  logic [37:0] km5_q;
  logic [31:0] dmx, dmy;
  assign dmx = dl4_q[15:0] * mx4_q;
  assign dmy = dl4_q[15:0] * my4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      int5_q <= int4_q; sx5_q <= sx4_q; sy5_q <= sy4_q; d5_q <= d4_q;
      nx5_q  <= {dmx, 8'd0};
      ny5_q  <= {dmy, 8'd0};
      km5_q  <= km4_q;
    end
  end

  // ---- dividers
  localparam int unsigned DvSideW = 1 + 1 + 1 + 38;
  logic              vdx, vdy;
  logic [39:0]       qx, qy;
  logic [DvSideW-1:0] dsx, dsy;
  cpsf_div #(.NumW(40), .DenW(17), .SideW(DvSideW)) u_div_x (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .num_i(nx5_q), .den_i(d5_q),
    .side_i({int5_q, sx5_q, sy5_q, km5_q}),
    .valid_o(vdx), .quo_o(qx), .side_o(dsx)
  );
  cpsf_div #(.NumW(40), .DenW(17), .SideW(DvSideW)) u_div_y (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .num_i(ny5_q), .den_i(d5_q),
    .side_i('0),
    .valid_o(vdy), .quo_o(qy), .side_o(dsy)
  );

  logic        int_d, sx_d, sy_d;
  logic [37:0] km_d;
  assign {int_d, sx_d, sy_d, km_d} = dsx;

  // ---- stage 6/7: km * q split in 19-bit halves (q < 2^24)
  logic        v6_q, int6_q, sx6_q, sy6_q;
  logic [23:0] qx6_q, qy6_q;
  logic [37:0] km6_q;
  logic        v7_q, int7_q, sx7_q, sy7_q;
  logic [42:0] xl7_q, xh7_q, yl7_q, yh7_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0; v7_q <= 1'b0;
    end else if (en) begin
      v6_q <= vdx && vdy; v7_q <= v6_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      int6_q <= int_d; sx6_q <= sx_d; sy6_q <= sy_d; km6_q <= km_d;
      qx6_q <= qx[23:0] | {23'd0, |dsy};
      qy6_q <= qy[23:0];
      int7_q <= int6_q; sx7_q <= sx6_q; sy7_q <= sy6_q;
      xl7_q <= km6_q[18:0]  * qx6_q;
      xh7_q <= km6_q[37:19] * qx6_q;
      yl7_q <= km6_q[18:0]  * qy6_q;
      yh7_q <= km6_q[37:19] * qy6_q;
    end
  end

  // ---- stage 8: combine, shift, saturate
  logic [62:0] px, py;
  logic [38:0] rx, ry;
  logic        cx, cy;
  logic [31:0] fx, fy;
  always_comb begin
    px = {20'd0, xl7_q} + {1'b0, xh7_q, 19'd0};
    py = {20'd0, yl7_q} + {1'b0, yh7_q, 19'd0};
    rx = px[62:24];
    ry = py[62:24];
    cx = sx7_q ? (rx > 39'h80000000) : (rx > 39'h7FFFFFFF);
    cy = sy7_q ? (ry > 39'h80000000) : (ry > 39'h7FFFFFFF);
    fx = cx ? (sx7_q ? 32'h80000000 : 32'h7FFFFFFF) : (sx7_q ? 32'd0 - rx[31:0] : rx[31:0]);
    fy = cy ? (sy7_q ? 32'h80000000 : 32'h7FFFFFFF) : (sy7_q ? 32'd0 - ry[31:0] : ry[31:0]);
  end

  logic [OutW-1:0] out_q;
  logic [1:0]      user_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= int7_q ? {fy, fx} : '0;
      user_q <= int7_q ? {cx || cy, 1'b1} : 2'b00;
    end
  end
  assign m_axis_tdata = out_q;
  assign m_axis_tuser = user_q;
endmodule

// File: sv/cpsf_checker.sv
module cpsf_checker import cpsf_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata,
  input logic [1:0]      m_axis_tuser
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipe stalled");
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("nonzero force on non-interacting pair");
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("clip without interaction");
endmodule

bind cell_pair_spring_force cpsf_checker u_cpsf_checker (.*);

// File: tb/sv/tb_cell_pair_spring_force.sv
module tb_cell_pair_spring_force;
  import cpsf_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned RandPerPhase  = 208;
  localparam int unsigned PhaseCount    = 5;
  localparam int unsigned DrainCycles   = 70;

  // One pair, most significant field first so that {pad, pair} is the tdata layout.
  typedef struct packed {
    logic [15:0] integrin_b;
    logic [15:0] pcad_b;
    logic [15:0] ecad_b;
    logic [15:0] integrin_a;
    logic [15:0] pcad_a;
    logic [15:0] ecad_a;
    logic [9:0]  cell_of_b;
    logic [9:0]  cell_of_a;
    logic [15:0] pos_b_y;
    logic [15:0] pos_b_x;
    logic [15:0] pos_a_y;
    logic [15:0] pos_a_x;
  } node_pair_t;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic        interacting;
    logic        clipped;
  } spring_res_t;

  typedef struct {
    node_pair_t  pair;
    bit          typed;   // expected result given in the row
    spring_res_t res;
  } pair_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i = '0;
  logic [31:0]      cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  // Register shadows used by the force predictor.
  logic [19:0] spring_k   = SpringConstReset;
  logic [15:0] rest_len   = RestLengthReset;
  logic [15:0] reach_dist = InterDistReset;

  spring_res_t force_queue[$];
  int unsigned errors     = 0;
  int unsigned pairs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen  = 0;
  int unsigned clips_seen = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;  // no idling on either side while set

  pair_row_t directed_rows[$];

  cell_pair_spring_force DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Floor square root, bit by bit; squared distance stays below 2^34.
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 17; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic spring_res_t predict_force(node_pair_t p);
    spring_res_t res;
    logic [63:0] mag[2];
    bit          neg[2];
    logic [63:0] d2, d, m, km, dl, q, r, limit;
    bit          dneg, sneg;
    logic [15:0] pa[2];
    logic [15:0] pb[2];
    res = '0;
    pa[0] = p.pos_a_x; pa[1] = p.pos_a_y;
    pb[0] = p.pos_b_x; pb[1] = p.pos_b_y;
    for (int i = 0; i < 2; i++) begin
      neg[i] = pb[i] < pa[i];
      mag[i] = neg[i] ? 64'(pa[i] - pb[i]) : 64'(pb[i] - pa[i]);
    end
    d2 = mag[0] * mag[0] + mag[1] * mag[1];
    if (p.cell_of_a == p.cell_of_b || d2 == 0 || d2 >= 64'(reach_dist) * 64'(reach_dist))
      return res;
    res.interacting = 1'b1;
    d  = isqrt(d2);
    m  = ((p.ecad_a < p.ecad_b) ? 64'(p.ecad_a) : 64'(p.ecad_b))
       + ((p.pcad_a < p.pcad_b) ? 64'(p.pcad_a) : 64'(p.pcad_b))
       + ((p.integrin_a > p.integrin_b) ? 64'(p.integrin_a) : 64'(p.integrin_b));
    km = 64'(spring_k) * m;
    dneg = d < 64'(rest_len);
    dl   = dneg ? 64'(rest_len) - d : d - 64'(rest_len);
    for (int i = 0; i < 2; i++) begin
      q = ((dl * mag[i]) << 8) / d;
      r = (km * q) >> 24;
      sneg  = dneg != neg[i];
      limit = sneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (r > limit) begin
        r = limit;
        res.clipped = 1'b1;
      end
      if (i == 0) res.force_x = sneg ? 32'(-r) : r[31:0];
      else        res.force_y = sneg ? 32'(-r) : r[31:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d, %s: got %h, expected %h", results_seen, field, got,
             want);
    errors++;
  endtask

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic logic [15:0] clamp16(int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // Mostly pairs near each other, some far pairs, same-cell pairs and zero-distance pairs.
  function automatic node_pair_t rand_pair();
    node_pair_t p;
    int span;
    p = node_pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 99) < 80) begin
      span = int'(reach_dist) + int'(reach_dist) / 4 + 2;
      p.pos_b_x = clamp16(int'(p.pos_a_x) + int'($urandom_range(0, 2 * span)) - span);
      p.pos_b_y = clamp16(int'(p.pos_a_y) + int'($urandom_range(0, 2 * span)) - span);
    end
    if ($urandom_range(0, 99) < 10) p.cell_of_b = p.cell_of_a;
    else if ($urandom_range(0, 99) < 3) begin
      p.pos_b_x = p.pos_a_x;
      p.pos_b_y = p.pos_a_y;
    end
    return p;
  endfunction

  // Register write over the config channel; block is idle here.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegSpringConst: spring_k   = val[19:0];
      RegRestLength:  rest_len   = val[15:0];
      default:        reach_dist = val[15:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drive one pair; the expectation is queued at the accepting edge.
  task automatic send_pair(node_pair_t p, bit typed, spring_res_t want);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, p};
    do @(posedge clk_i); while (!s_axis_tready);
    force_queue = {force_queue, (typed ? want : predict_force(p))};
    pairs_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (force_queue.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic node_pair_t mk(int ax, int ay, int bx, int by, int ca, int cb,
                                    int prot);
    node_pair_t p;
    p.pos_a_x = 16'(ax); p.pos_a_y = 16'(ay);
    p.pos_b_x = 16'(bx); p.pos_b_y = 16'(by);
    p.cell_of_a = 10'(ca); p.cell_of_b = 10'(cb);
    p.ecad_a = 16'(prot); p.pcad_a = 16'(prot); p.integrin_a = 16'(prot);
    p.ecad_b = 16'(prot); p.pcad_b = 16'(prot); p.integrin_b = 16'(prot);
    return p;
  endfunction

  function automatic void add_row(node_pair_t p, bit typed, spring_res_t want);
    pair_row_t row;
    row.pair = p;
    row.typed = typed;
    row.res = want;
    directed_rows = {directed_rows, row};
  endfunction

  // Receiver: random backpressure, compares every result with the oldest expectation.
  initial begin
    int stall;
    spring_res_t want;
    spring_res_t got;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0], m_axis_tuser[1]};
      if (force_queue.size() == 0) begin
        report_mismatch("unexpected result, force_x", got.force_x, 32'd0);
      end else begin
        want = force_queue.pop_front();
        if (got.force_x !== want.force_x) report_mismatch("force_x", got.force_x, want.force_x);
        if (got.force_y !== want.force_y) report_mismatch("force_y", got.force_y, want.force_y);
        if (got.interacting !== want.interacting)
          report_mismatch("interacting", 32'(got.interacting), 32'(want.interacting));
        if (got.clipped !== want.clipped)
          report_mismatch("clipped", 32'(got.clipped), 32'(want.clipped));
        hits_seen  += want.interacting;
        clips_seen += want.clipped;
      end
      results_seen++;
    end
  end

  // Watchdog: cycles with no transaction on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    spring_res_t zero_res;
    spring_res_t slack_res;
    zero_res  = '0;
    slack_res = '0;
    slack_res.interacting = 1'b1;  // interacting, no force

    // Directed rows under the reset register values.
    add_row(mk(1000, 1000, 1200, 1000, 5, 5, 256), 1, zero_res);       // same cell
    add_row(mk(4000, 4000, 4000, 4000, 1, 2, 256), 1, zero_res);       // zero distance
    add_row(mk(0, 0, 65535, 65535, 0, 1023, 65535), 1, zero_res);      // far apart
    add_row(mk(100, 200, 1411, 200, 3, 4, 256), 1, zero_res);          // at reach, excluded
    add_row(mk(100, 200, 1410, 200, 3, 4, 256), 0, zero_res);          // just inside
    add_row(mk(500, 500, 600, 550, 7, 8, 256), 0, zero_res);           // compressed
    add_row(mk(60000, 60000, 59400, 59300, 9, 10, 300), 0, zero_res);  // B below A
    add_row(mk(65535, 65535, 64535, 64900, 1023, 0, 65535), 0, zero_res);
    add_row(mk(0, 0, 700, 700, 0, 1023, 65535), 0, zero_res);
    add_row(mk(300, 300, 900, 300, 1, 2, 0), 1, slack_res);            // no protein
    add_row(mk(300, 300, 628, 300, 1, 2, 512), 1, slack_res);          // at rest length
    add_row(mk(300, 700, 300, 200, 1, 2, 512), 0, zero_res);           // y only

    #1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].res);
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        1: begin  // strongest spring, widest reach: saturation
          write_reg(RegSpringConst, 32'hFFFFF);
          write_reg(RegRestLength, 32'd0);
          write_reg(RegInterDist, 32'hFFFF);
        end
        2: begin  // zero spring, full rest length
          write_reg(RegSpringConst, 32'd0);
          write_reg(RegRestLength, 32'hFFFF);
          write_reg(RegInterDist, 32'd4000);
        end
        3: begin
          write_reg(RegSpringConst, $urandom);
          write_reg(RegRestLength, $urandom_range(0, 3000));
          write_reg(RegInterDist, $urandom_range(1, 6000));
        end
        4: begin  // back to defaults, a zero reach first
          write_reg(RegInterDist, 32'd0);
          send_pair(mk(10, 10, 11, 10, 1, 2, 256), 1, zero_res);
          drain();
          write_reg(RegSpringConst, SpringConstReset);
          write_reg(RegRestLength, RestLengthReset);
          write_reg(RegInterDist, InterDistReset);
        end
        default: ;
      endcase
      quiet = (ph == 2);
      for (int n = 0; n < RandPerPhase; n++) send_pair(rand_pair(), 0, zero_res);
      drain();
    end

    quiet = 1'b0;
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d pairs under %0d register settings: %0d interacting, %0d saturated",
             pairs_sent, PhaseCount + 1, hits_seen, clips_seen);
    $display("%0d results compared, %0d mismatches", results_seen, errors);
    if (errors == 0 && force_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
